[sv/sukt_pkg.sv]
// Shared types and constants for the sorted unique key table.
// No dependencies; every other file of the block imports this package.
package sukt_pkg;

  localparam int unsigned KEY_W            = 32;
  localparam int unsigned POS_W            = 7;
  localparam int unsigned DEFAULT_CAPACITY = 32;

  // Command codes as they arrive on the command port.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_DUP      = 3'd1,
    STATUS_NOTFOUND = 3'd2,
    STATUS_FULL     = 3'd3,
    STATUS_EMPTY    = 3'd4
  } status_e;

  // Operation broadcast to every cell of the row.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  // Control group that the sequencer hands to all cells.
  typedef struct packed {
    cell_op_e          op;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

[sv/sukt_cell.sv]
// One cell of the key row: holds one key, compares it with the command key
// and shifts left, right or rotates with its neighbors. Depends on sukt_pkg.
module sukt_cell (
  input  logic                            clk_i,
  input  sukt_pkg::cell_ctl_t             ctl_i,
  input  logic                            valid_i,
  input  logic                            tail_i,
  input  logic                            left_lt_i,
  input  logic signed [sukt_pkg::KEY_W-1:0] left_key_i,
  input  logic signed [sukt_pkg::KEY_W-1:0] right_key_i,
  input  logic signed [sukt_pkg::KEY_W-1:0] wrap_key_i,
  output logic signed [sukt_pkg::KEY_W-1:0] key_o,
  output logic                            lt_o,
  output logic                            eq_o
);
  import sukt_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;

  // Compare the held key with the command key; empty cells never match.
  assign lt_o  = valid_i && (key_q < ctl_i.key);
  assign eq_o  = valid_i && (key_q == ctl_i.key);
  assign key_o = key_q;

  // Cells at or above the insertion point move one place toward the tail;
  // cells at or above a deleted key pull from the tail side.
  always_comb begin
    key_d = key_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (!lt_o) begin
          key_d = left_lt_i ? ctl_i.key : left_key_i;
        end
      end
      OP_DELETE: begin
        if (!lt_o) begin
          key_d = right_key_i;
        end
      end
      OP_ROTATE: begin
        if (valid_i) begin
          key_d = tail_i ? wrap_key_i : right_key_i;
        end
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[sv/sorted_unique_key_table.sv]
// Sorted unique key table: a row of CAPACITY compare-and-shift cells.
// Insert, delete and search execute in S_EXEC; no new command is taken until it ends.
// Dump: one result per stored key on consecutive cycles, set by
// the row rotating one place per cycle; an empty dump gives one result.
// Reset (rst_ni low, asynchronous) empties the table; key storage is not cleared.
// Results are shown for one cycle only: the receiver cannot stall.
module sorted_unique_key_table #(
  parameter int unsigned CAPACITY = sukt_pkg::DEFAULT_CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd_i,
  input  logic signed [sukt_pkg::KEY_W-1:0] key_i,
  output logic                              res_valid_o,
  output logic [2:0]                        status_o,
  output logic signed [sukt_pkg::KEY_W-1:0] key_out_o,
  output logic [sukt_pkg::POS_W-1:0]        position_o,
  output logic [sukt_pkg::POS_W-1:0]        entry_count_o,
  output logic                              last_o
);
  import sukt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_e                  state_q, state_d;
  cmd_e                    cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        dump_idx_q, dump_idx_d;

  logic                    res_valid_q, res_valid_d;
  status_e                 status_q, status_d;
  logic signed [KEY_W-1:0] key_out_q, key_out_d;
  logic [POS_W-1:0]        position_q, position_d;
  logic [POS_W-1:0]        count_out_q, count_out_d;
  logic                    last_q, last_d;

  cell_ctl_t               ctl;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     cell_lt, cell_eq, cell_valid, cell_tail, cell_left_lt;
  logic                    hit, full, accept, dump_last;
  logic [IDX_W-1:0]        hit_idx, ins_idx;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Row of cells; each sees its neighbors' keys and its left neighbor's compare.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [KEY_W-1:0] left_key, right_key;

    assign cell_valid[j] = CNT_W'(j) < count_q;

    if (j == 0) begin : g_head
      assign cell_left_lt[j] = 1'b1;
      assign left_key        = cell_key[j];
    end else begin : g_body
      assign cell_left_lt[j] = cell_lt[j-1];
      assign left_key        = cell_key[j-1];
    end

    if (j == CAPACITY - 1) begin : g_end
      assign right_key    = cell_key[j];
      assign cell_tail[j] = cell_valid[j];
    end else begin : g_mid
      assign right_key    = cell_key[j+1];
      assign cell_tail[j] = cell_valid[j] && !cell_valid[j+1];
    end

    sukt_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (cell_valid[j]),
      .tail_i     (cell_tail[j]),
      .left_lt_i  (cell_left_lt[j]),
      .left_key_i (left_key),
      .right_key_i(right_key),
      .wrap_key_i (cell_key[0]),
      .key_o      (cell_key[j]),
      .lt_o       (cell_lt[j]),
      .eq_o       (cell_eq[j])
    );
  end

  // Encode the one-hot match and the insertion boundary into indexes.
  always_comb begin
    hit_idx = '0;
    ins_idx = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (cell_eq[j]) begin
        hit_idx = hit_idx | IDX_W'(j);
      end
      if (!cell_lt[j] && cell_left_lt[j]) begin
        ins_idx = ins_idx | IDX_W'(j);
      end
    end
  end

  assign hit       = |cell_eq;
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign dump_last = (CNT_W'(dump_idx_q) == count_q - CNT_W'(1));

  // Sequencer: decide the row operation and build the result beat.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dump_idx_d  = dump_idx_q;
    ctl.op      = OP_HOLD;
    ctl.key     = key_q;
    res_valid_d = 1'b0;
    status_d    = STATUS_OK;
    key_out_d   = key_q;
    position_d  = '0;
    count_out_d = POS_W'(count_q);
    last_d      = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
        case (cmd_q)
          CMD_INSERT: begin
            if (hit) begin
              status_d   = STATUS_DUP;
              position_d = POS_W'(hit_idx);
            end else if (full) begin
              status_d = STATUS_FULL;
            end else begin
              ctl.op      = OP_INSERT;
              count_d     = count_q + CNT_W'(1);
              position_d  = POS_W'(ins_idx);
              count_out_d = POS_W'(count_d);
            end
          end
          CMD_DELETE: begin
            if (hit) begin
              ctl.op      = OP_DELETE;
              count_d     = count_q - CNT_W'(1);
              position_d  = POS_W'(hit_idx);
              count_out_d = POS_W'(count_d);
            end else begin
              status_d = STATUS_NOTFOUND;
            end
          end
          CMD_SEARCH: begin
            if (hit) begin
              position_d = POS_W'(hit_idx);
            end else begin
              status_d = STATUS_NOTFOUND;
            end
          end
          CMD_DUMP: begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
            end else begin
              res_valid_d = 1'b0;
              dump_idx_d  = '0;
              state_d     = S_DUMP;
            end
          end
          default: res_valid_d = 1'b0;
        endcase
      end
      S_DUMP: begin
        // Head cell carries the next key out while the row rotates.
        ctl.op      = OP_ROTATE;
        res_valid_d = 1'b1;
        key_out_d   = cell_key[0];
        position_d  = POS_W'(dump_idx_q);
        last_d      = dump_last;
        if (dump_last) begin
          state_d = S_IDLE;
        end else begin
          dump_idx_d = dump_idx_q + IDX_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Command capture and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= key_i;
    end
    status_q    <= status_d;
    key_out_q   <= key_out_d;
    position_q  <= position_d;
    count_out_q <= count_out_d;
    last_q      <= last_d;
  end

  assign res_valid_o   = res_valid_q;
  assign status_o      = status_q;
  assign key_out_o     = key_out_q;
  assign position_o    = position_q;
  assign entry_count_o = count_out_q;
  assign last_o        = last_q;

endmodule

[sv/sukt_checker.sv]
// Port-level checks for the sorted unique key table, and the bind that
// attaches them to it. Depends on sukt_pkg and sorted_unique_key_table.
module sukt_checker #(
  parameter int unsigned CAPACITY = sukt_pkg::DEFAULT_CAPACITY
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              res_valid_o,
  input logic [2:0]                        status_o,
  input logic [sukt_pkg::POS_W-1:0]        entry_count_o,
  input logic                              last_o
);
  import sukt_pkg::*;

  // An accepted command holds the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after an accepted command");

  // No result beat in the cycle right after a command is taken.
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !res_valid_o)
    else $error("result beat directly after accept");

  // A dump streams its beats without gaps until the last one.
  a_dump_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> res_valid_o)
    else $error("gap inside a dump");

  // An empty dump is a single final beat reporting zero entries.
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (status_o == STATUS_EMPTY) |-> last_o && (entry_count_o == '0))
    else $error("empty status with wrong count or last flag");

  // A full report only comes with a table at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (status_o == STATUS_FULL) |-> (entry_count_o == POS_W'(CAPACITY)))
    else $error("full status below capacity");

endmodule

bind sorted_unique_key_table sukt_checker #(.CAPACITY(CAPACITY)) u_sukt_checker (.*);

[bench/sorted_unique_key_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sorted unique key table.
// Depends on sukt_pkg and sorted_unique_key_table; predicts every result beat internally.
module sorted_unique_key_table_tb;
  import sukt_pkg::*;

  localparam int unsigned CAPACITY    = 32;
  localparam time         CLK_PERIOD  = 8ns;
  localparam int          RESET_CYCLES = 7;
  localparam int          TAIL_CYCLES  = 40;
  localparam int          CYCLE_LIMIT  = 200000;

  // One result beat as the block should present it.
  typedef struct packed {
    status_e                 status;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        entry_count;
    logic                    last;
  } table_result_t;

  logic                    clk_i  = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start  = 1'b0;
  logic                    busy;
  logic [1:0]              cmd_i  = '0;
  logic signed [KEY_W-1:0] key_i  = '0;
  logic                    res_valid_o;
  logic [2:0]              status_o;
  logic signed [KEY_W-1:0] key_out_o;
  logic [POS_W-1:0]        position_o;
  logic [POS_W-1:0]        entry_count_o;
  logic                    last_o;

  // Mirror of the table contents, kept in ascending order.
  logic signed [KEY_W-1:0] table_keys[$];
  logic signed [KEY_W-1:0] key_pool[$];
  table_result_t           pending_results[$];
  table_result_t           exp_res;
  int                      error_count = 0;
  int                      cycle_count = 0;
  bit                      sender_gaps = 1'b1;

  sorted_unique_key_table #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .res_valid_o  (res_valid_o),
    .status_o     (status_o),
    .key_out_o    (key_out_o),
    .position_o   (position_o),
    .entry_count_o(entry_count_o),
    .last_o       (last_o)
  );

  // Free-running clock.
  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Append one expected result beat.
  function automatic void queue_result(input status_e st, input logic signed [KEY_W-1:0] k,
                                       input int pos, input int cnt, input logic lst);
    table_result_t r;
    r.status      = st;
    r.key         = k;
    r.position    = POS_W'(pos);
    r.entry_count = POS_W'(cnt);
    r.last        = lst;
    pending_results.push_back(r);
  endfunction

  // Apply one command to the mirrored table and queue the beats it produces.
  function automatic void predict_table_cmd(input cmd_e op, input logic signed [KEY_W-1:0] key);
    int slot;
    bit hit;
    slot = 0;
    while (slot < table_keys.size() && table_keys[slot] < key) slot++;
    hit = (slot < table_keys.size()) && (table_keys[slot] == key);
    case (op)
      CMD_DUMP: begin
        if (table_keys.size() == 0) begin
          queue_result(STATUS_EMPTY, key, 0, 0, 1'b1);
        end else begin
          for (int j = 0; j < table_keys.size(); j++) begin
            queue_result(STATUS_OK, table_keys[j], j, table_keys.size(),
                         j == table_keys.size() - 1);
          end
        end
      end
      CMD_INSERT: begin
        // A duplicate is reported even when the table is full.
        if (hit) begin
          queue_result(STATUS_DUP, key, slot, table_keys.size(), 1'b1);
        end else if (table_keys.size() >= CAPACITY) begin
          queue_result(STATUS_FULL, key, 0, table_keys.size(), 1'b1);
        end else begin
          table_keys.insert(slot, key);
          queue_result(STATUS_OK, key, slot, table_keys.size(), 1'b1);
        end
      end
      CMD_DELETE: begin
        if (!hit) begin
          queue_result(STATUS_NOTFOUND, key, 0, table_keys.size(), 1'b1);
        end else begin
          table_keys.delete(slot);
          queue_result(STATUS_OK, key, slot, table_keys.size(), 1'b1);
        end
      end
      default: begin
        if (hit) queue_result(STATUS_OK, key, slot, table_keys.size(), 1'b1);
        else     queue_result(STATUS_NOTFOUND, key, 0, table_keys.size(), 1'b1);
      end
    endcase
  endfunction

  // Report one field that differs from its prediction.
  task automatic compare_field(input string field, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Result checker and run watchdog, both on the rising edge.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none actual status %0d key %0h",
                 $time, status_o, key_out_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("status", exp_res.status, status_o);
        compare_field("key_out", exp_res.key, key_out_o);
        compare_field("position", exp_res.position, position_o);
        compare_field("entry_count", exp_res.entry_count, entry_count_o);
        compare_field("last", exp_res.last, last_o);
      end
    end
  end

  // Send one command beat. Called at a falling edge; returns at a falling edge
  // with start still high, so back-to-back beats need no gap.
  task automatic send_beat(input cmd_e op, input logic signed [KEY_W-1:0] key);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    start = 1'b1;
    cmd_i = op;
    key_i = key;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    predict_table_cmd(op, key);
  endtask

  // Stop sending and wait until every predicted beat has arrived.
  task automatic wait_results_done();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Choose a key that often hits the table, sometimes the pool, rarely anything.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && table_keys.size() != 0)
      return table_keys[$urandom_range(0, table_keys.size() - 1)];
    else if (sel < 9)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    else
      return $urandom();
  endfunction

  // Key extremes, every command, empty-table and duplicate cases.
  task automatic test_directed_edges();
    send_beat(CMD_DUMP, 32'h5A5A_A5A5);
    send_beat(CMD_SEARCH, 0);
    send_beat(CMD_DELETE, 7);
    send_beat(CMD_INSERT, 0);
    send_beat(CMD_INSERT, 32'sh7FFF_FFFF);
    send_beat(CMD_INSERT, 32'sh8000_0000);
    send_beat(CMD_INSERT, -1);
    send_beat(CMD_INSERT, 1);
    send_beat(CMD_INSERT, 0);
    send_beat(CMD_INSERT, 32'sh8000_0000);
    send_beat(CMD_DUMP, 0);
    send_beat(CMD_SEARCH, 32'sh8000_0000);
    send_beat(CMD_SEARCH, 32'sh7FFF_FFFF);
    send_beat(CMD_SEARCH, 2);
    send_beat(CMD_DELETE, -1);
    send_beat(CMD_DELETE, -1);
    send_beat(CMD_DELETE, 32'sh7FFF_FFFF);
    send_beat(CMD_DUMP, 32'hFFFF_FFFF);
    send_beat(CMD_DELETE, 32'sh8000_0000);
    send_beat(CMD_DELETE, 0);
    send_beat(CMD_DELETE, 1);
    send_beat(CMD_DUMP, 32'hFFFF_FFFF);
    send_beat(CMD_SEARCH, 1);
  endtask

  // Fill the table with random keys, then probe the full and duplicate cases.
  task automatic test_fill_to_capacity();
    logic signed [KEY_W-1:0] k;
    while (table_keys.size() < CAPACITY) send_beat(CMD_INSERT, $urandom());
    do k = $urandom(); while (k inside {table_keys});
    send_beat(CMD_INSERT, k);
    send_beat(CMD_INSERT, table_keys[$urandom_range(0, CAPACITY - 1)]);
    send_beat(CMD_INSERT, table_keys[0]);
    send_beat(CMD_INSERT, table_keys[CAPACITY - 1]);
    send_beat(CMD_DUMP, 0);
    send_beat(CMD_SEARCH, table_keys[CAPACITY - 1]);
    send_beat(CMD_DELETE, table_keys[0]);
    send_beat(CMD_INSERT, k);
    send_beat(CMD_DUMP, 0);
    // Drain back to a handful of entries so the mixed traffic starts mid-range.
    while (table_keys.size() > 6)
      send_beat(CMD_DELETE, table_keys[$urandom_range(0, table_keys.size() - 1)]);
  endtask

  // Mixed traffic with a given insert weight (percent); dumps take a tenth.
  task automatic test_random_traffic(input int beats, input int insert_weight);
    int roll;
    int delete_weight;
    delete_weight = (90 - insert_weight) / 2;
    for (int n = 0; n < beats; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_weight)                      send_beat(CMD_INSERT, pick_key());
      else if (roll < insert_weight + delete_weight) send_beat(CMD_DELETE, pick_key());
      else if (roll < 90)                            send_beat(CMD_SEARCH, pick_key());
      else                                           send_beat(CMD_DUMP, $urandom());
    end
  endtask

  initial begin
    // Pool of 48 keys: extremes plus random values, more than the table holds.
    key_pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1};
    while (key_pool.size() < 48) key_pool.push_back($urandom());

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_edges();
    wait_results_done();
    test_fill_to_capacity();
    test_random_traffic(110, 60);
    wait_results_done();
    test_random_traffic(100, 20);
    sender_gaps = 1'b0;
    test_random_traffic(80, 40);

    wait_results_done();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
